// ===== design/e2q_pkg.sv =====
// Shared constants and types for the Euler-angle to quaternion pipeline.
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int AngW   = 17;
  localparam int QW     = 16;
  localparam int Steps  = 18;
  localparam int XW     = 32;
  localparam int ZW     = 26;
  localparam int FullTurn    = 92160;
  localparam int HalfTurn    = 46080;
  localparam int QuarterTurn = 23040;
  localparam logic signed [XW-1:0] CordicGain = 32'sd652032874;

  typedef logic signed [QW-1:0] q15_t;
  // Rounded sine/cosine: one extra bit so that +1.0 (32768) is carried exactly
  typedef logic signed [QW:0] trig_t;

  // Arctangent of 2^-i in units of 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    begin
      unique case (idx)
        5'd0: v = 26'sd2949120;  5'd1: v = 26'sd1740967;
        5'd2: v = 26'sd919879;   5'd3: v = 26'sd466945;
        5'd4: v = 26'sd234379;   5'd5: v = 26'sd117304;
        5'd6: v = 26'sd58666;    5'd7: v = 26'sd29335;
        5'd8: v = 26'sd14668;    5'd9: v = 26'sd7334;
        5'd10: v = 26'sd3667;    5'd11: v = 26'sd1833;
        5'd12: v = 26'sd917;     5'd13: v = 26'sd458;
        5'd14: v = 26'sd229;     5'd15: v = 26'sd115;
        5'd16: v = 26'sd57;      5'd17: v = 26'sd29;
        default: v = '0;
      endcase
      return v;
    end
  endfunction
endpackage

// ===== design/e2q_sincos.sv =====
// Pipelined sine/cosine of a half angle: range reduction plus 18 CORDIC stages.
`timescale 1ns / 1ps
module e2q_sincos (
  input  logic                         clk_i,
  input  logic signed [e2q_pkg::AngW-1:0] ang_i,
  output e2q_pkg::trig_t               sin_o,
  output e2q_pkg::trig_t               cos_o
);
  import e2q_pkg::*;

  // Range reduction, registered
  logic signed [18:0] t0, t1, t2;
  logic               neg_d;
  logic signed [18:0] tr_d;
  logic signed [18:0] tr_q;
  logic               neg_q;
  always_comb begin
    t0 = 19'(ang_i);
    // Input lies in [-65536,65535]: at most one turn to fold
    if (t0 > 19'(HalfTurn)) t1 = t0 - 19'(FullTurn);
    else if (t0 <= -19'(HalfTurn)) t1 = t0 + 19'(FullTurn);
    else t1 = t0;
    t2 = t1;
    neg_d = 1'b0;
    if (t1 > 19'(QuarterTurn)) begin
      t2 = 19'(HalfTurn) - t1;
      neg_d = 1'b1;
    end else if (t1 < -19'(QuarterTurn)) begin
      t2 = -19'(HalfTurn) - t1;
      neg_d = 1'b1;
    end
    tr_d = t2;
  end
  always_ff @(posedge clk_i) begin
    tr_q  <= tr_d;
    neg_q <= neg_d;
  end

  // CORDIC stage registers
  logic signed [XW-1:0] x_q [Steps+1];
  logic signed [XW-1:0] y_q [Steps+1];
  logic signed [ZW-1:0] z_q [Steps+1];
  logic                 n_q [Steps+1];
  assign x_q[0] = CordicGain;
  assign y_q[0] = '0;
  assign z_q[0] = {tr_q[17:0], 8'd0};
  assign n_q[0] = neg_q;

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - atan_lut(5'(i));
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + atan_lut(5'(i));
      end
      n_q[i+1] <= n_q[i];
    end
  end

  // Round Q30 to Q15 and apply cosine sign
  logic signed [XW:0] sr, cr;
  trig_t c17;
  assign sr  = (33'(y_q[Steps]) + 33'sd16384) >>> 15;
  assign cr  = (33'(x_q[Steps]) + 33'sd16384) >>> 15;
  assign c17 = cr[QW:0];
  always_ff @(posedge clk_i) begin
    sin_o <= sr[QW:0];
    cos_o <= n_q[Steps] ? -c17 : c17;
  end
endmodule

// ===== design/e2q_combine.sv =====
// Quaternion component combiner: two multiply stages, sum, round, saturate.
`timescale 1ns / 1ps
module e2q_combine (
  input  logic           clk_i,
  input  e2q_pkg::trig_t sp_i, cp_i, sr_i, cr_i, sy_i, cy_i,
  output e2q_pkg::q15_t  c0_o, c1_o, c2_o, c3_o
);
  import e2q_pkg::*;

  // Stage 1: yaw x pitch products (Q30)
  logic signed [31:0] cc_q, cs_q, sc_q, ss_q;
  trig_t sr_q, cr_q;
  always_ff @(posedge clk_i) begin
    cc_q <= cy_i * cp_i;
    cs_q <= cy_i * sp_i;
    sc_q <= sy_i * cp_i;
    ss_q <= sy_i * sp_i;
    sr_q <= sr_i;
    cr_q <= cr_i;
  end

  // Stage 2: times roll terms (Q45)
  logic signed [47:0] p [8];
  always_ff @(posedge clk_i) begin
    p[0] <= cc_q * cr_q; p[1] <= ss_q * sr_q;
    p[2] <= cs_q * cr_q; p[3] <= sc_q * sr_q;
    p[4] <= cc_q * sr_q; p[5] <= ss_q * cr_q;
    p[6] <= cs_q * sr_q; p[7] <= sc_q * cr_q;
  end

  // Stage 3: sum and round
  logic signed [48:0] s_q [4];
  always_ff @(posedge clk_i) begin
    s_q[0] <= ((49'(p[0]) - 49'(p[1])) + 49'sd536870912) >>> 30;
    s_q[1] <= ((49'(p[2]) - 49'(p[3])) + 49'sd536870912) >>> 30;
    s_q[2] <= ((49'(p[4]) + 49'(p[5])) + 49'sd536870912) >>> 30;
    s_q[3] <= ((49'(p[6]) + 49'(p[7])) + 49'sd536870912) >>> 30;
  end

  function automatic q15_t sat(input logic signed [48:0] v);
    if (v > 49'sd32767) return 16'sh7fff;
    if (v < -49'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Stage 4: saturate
  always_ff @(posedge clk_i) begin
    c0_o <= sat(s_q[0]);
    c1_o <= sat(s_q[1]);
    c2_o <= sat(s_q[2]);
    c3_o <= sat(s_q[3]);
  end
endmodule

// ===== design/euler_to_quaternion_unit.sv =====
// Pipeline from start to done_o: range reduction, CORDIC stages, rounding, then the combiner.
// Throughput: one item per cycle; busy is always low, set by the fully pipelined datapath.
// Reset (rst_ni, async low) clears the valid chain only; data registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done_o high.
`timescale 1ns / 1ps
module euler_to_quaternion_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [e2q_pkg::AngW-1:0] pitch_deg_i,
  input  logic signed [e2q_pkg::AngW-1:0] roll_deg_i,
  input  logic signed [e2q_pkg::AngW-1:0] yaw_deg_i,
  output logic                          done_o,
  output e2q_pkg::q15_t                 quat_c0_o,
  output e2q_pkg::q15_t                 quat_c1_o,
  output e2q_pkg::q15_t                 quat_c2_o,
  output e2q_pkg::q15_t                 quat_c3_o
);
  import e2q_pkg::*;
  localparam int Lat = Steps + 6;

  assign busy = 1'b0;

  trig_t sp, cp, sr, cr, sy, cy;
  e2q_sincos u_p (.clk_i, .ang_i(pitch_deg_i), .sin_o(sp), .cos_o(cp));
  e2q_sincos u_r (.clk_i, .ang_i(roll_deg_i),  .sin_o(sr), .cos_o(cr));
  e2q_sincos u_y (.clk_i, .ang_i(yaw_deg_i),   .sin_o(sy), .cos_o(cy));

  e2q_combine u_comb (
    .clk_i, .sp_i(sp), .cp_i(cp), .sr_i(sr), .cr_i(cr), .sy_i(sy), .cy_i(cy),
    .c0_o(quat_c0_o), .c1_o(quat_c1_o), .c2_o(quat_c2_o), .c3_o(quat_c3_o)
  );

  // Valid bit chain alongside the datapath
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end
  assign done_o = vld_q[Lat-1];
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Euler-angle to quaternion unit.
`timescale 1ns / 1ps
module tb;
  import e2q_pkg::*;

  typedef struct packed {
    logic signed [AngW-1:0] pitch;
    logic signed [AngW-1:0] roll;
    logic signed [AngW-1:0] yaw;
  } angles_t;

  typedef struct packed {
    q15_t c0;
    q15_t c1;
    q15_t c2;
    q15_t c3;
  } quat_t;

  localparam int NumRandom = 930;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [AngW-1:0] pitch_deg_i = '0;
  logic signed [AngW-1:0] roll_deg_i = '0;
  logic signed [AngW-1:0] yaw_deg_i = '0;
  logic done_o;
  q15_t quat_c0_o, quat_c1_o, quat_c2_o, quat_c3_o;

  angles_t pending_q[$];
  quat_t quat_expect_q[$];
  int n_errors = 0;
  int n_sent = 0;
  int n_quats = 0;
  int gap_left = 0;
  bit stim_done = 1'b0;

  euler_to_quaternion_unit dut (
    .clk_i, .rst_ni, .start, .busy,
    .pitch_deg_i, .roll_deg_i, .yaw_deg_i,
    .done_o, .quat_c0_o, .quat_c1_o, .quat_c2_o, .quat_c3_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Half-angle sine/cosine in Q15 by fixed 18-step CORDIC
  function automatic void half_sin_cos(input longint ang, output longint s15,
                                       output longint c15);
    longint t, x, y, z, dx, dy;
    bit flip_cos;
    t = (ang + 2 * FullTurn) % FullTurn;
    flip_cos = 1'b0;
    if (t > HalfTurn) t -= FullTurn;
    if (t > QuarterTurn) begin
      t = HalfTurn - t;
      flip_cos = 1'b1;
    end else if (t < -QuarterTurn) begin
      t = -HalfTurn - t;
      flip_cos = 1'b1;
    end
    x = CordicGain;
    y = 0;
    z = t * 256;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_lut(i[4:0]));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_lut(i[4:0]));
      end
    end
    s15 = (y + (1 << 14)) >>> 15;
    c15 = (x + (1 << 14)) >>> 15;
    if (flip_cos) c15 = -c15;
  endfunction

  // Q45 sum to saturated Q15
  function automatic q15_t round_sat(input longint q45);
    longint v;
    v = (q45 + (longint'(1) << 29)) >>> 30;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return q15_t'(v);
  endfunction

  function automatic quat_t angles_to_quat(input angles_t a);
    longint sp, cp, sr, cr, sy, cy;
    quat_t q;
    half_sin_cos(longint'(a.pitch), sp, cp);
    half_sin_cos(longint'(a.roll), sr, cr);
    half_sin_cos(longint'(a.yaw), sy, cy);
    q.c0 = round_sat(cy * cp * cr - sy * sp * sr);
    q.c1 = round_sat(cy * sp * cr - sy * cp * sr);
    q.c2 = round_sat(cy * cp * sr + sy * sp * cr);
    q.c3 = round_sat(cy * sp * sr + sy * cp * cr);
    return q;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic signed [AngW-1:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return AngW'($urandom);  // any 17-bit pattern, wraps
      1: return AngW'($urandom_range(0, 8) * 11520 - 46080);  // multiples of 90 deg
      default: return AngW'($urandom_range(0, 92160) - 46080);
    endcase
  endfunction

  // Directed corners, then random angle triples
  initial begin
    logic signed [AngW-1:0] corners[10];
    corners = '{17'sd0, 17'sd46080, -17'sd46080, 17'sd23040, -17'sd23040,
                17'sd65535, -17'sd65536, 17'sd11520, 17'sd23041, -17'sd1};
    foreach (corners[i])
      pending_q.push_back('{corners[i], corners[(i + 3) % 10], corners[(i + 7) % 10]});
    // identity-like and single-axis half turns to drive saturation
    pending_q.push_back('{17'sd0, 17'sd0, 17'sd0});
    pending_q.push_back('{17'sd46080, 17'sd0, 17'sd0});
    pending_q.push_back('{17'sd0, 17'sd46080, 17'sd0});
    pending_q.push_back('{17'sd0, 17'sd0, 17'sd46080});
    pending_q.push_back('{17'sd92160, -17'sd92160, 17'sd0});
    pending_q.push_back('{17'sd46080, 17'sd46080, 17'sd46080});
    pending_q.push_back('{17'sd11520, 17'sd11520, 17'sd11520});
    pending_q.push_back('{17'sh0AAAA, 17'sh15555, 17'sh1FFFF});
    pending_q.push_back('{17'sh15555, 17'sh0AAAA, 17'sh10000});
    for (int i = 0; i < NumRandom; i++)
      pending_q.push_back('{rand_angle(), rand_angle(), rand_angle()});
    stim_done = 1'b1;
  end

  // Driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && start && !busy) begin
      quat_expect_q.push_back(angles_to_quat('{pitch_deg_i, roll_deg_i, yaw_deg_i}));
      n_sent++;
      void'(pending_q.pop_front());
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    end
    if (!rst_ni || pending_q.size() == 0 || (gap_left > 0 && !(start && busy))) begin
      if (gap_left > 0 && !(start && busy)) gap_left--;
      if (!(start && busy)) start <= 1'b0;
    end else begin
      start <= 1'b1;
      pitch_deg_i <= pending_q[0].pitch;
      roll_deg_i <= pending_q[0].roll;
      yaw_deg_i <= pending_q[0].yaw;
    end
  end

  // Monitor: results sampled on the rising edge
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && done_o) begin
      n_quats++;
      if (quat_expect_q.size() == 0) begin
        report("unexpected result", quat_c0_o, 0);
      end else begin
        want = quat_expect_q.pop_front();
        if (quat_c0_o !== want.c0) report("c0", quat_c0_o, want.c0);
        if (quat_c1_o !== want.c1) report("c1", quat_c1_o, want.c1);
        if (quat_c2_o !== want.c2) report("c2", quat_c2_o, want.c2);
        if (quat_c3_o !== want.c3) report("c3", quat_c3_o, want.c3);
      end
    end
  end

  // Reset, then wait for drain
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (stim_done && pending_q.size() == 0 && !start);
    wait (quat_expect_q.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("Converted %0d angle triples, %0d quaternions checked, %0d mismatches",
             n_sent, n_quats, n_errors);
    if (n_errors == 0 && quat_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", quat_expect_q.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
